[hw/rtl/stable_id_packed_table_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the packed table
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_ID_PACKED_TABLE_TOP_DEFINES_SVH
`define STABLE_ID_PACKED_TABLE_TOP_DEFINES_SVH

// cond holds at every edge
`define SIPT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// cons holds in the cycle after ante
`define SIPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/sipt_pkg.sv]
// ----------------------------------------------------------------------------
// sipt_pkg
// Types and constants shared by the packed table controller and datapath.
// ----------------------------------------------------------------------------
package sipt_pkg;

   localparam int DEPTH  = 1024;
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ID_W   = ADDR_W;
   localparam int CNT_W  = ADDR_W + 1;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH     = 2'd0,
      OP_GET      = 2'd1,
      OP_DELETE   = 2'd2,
      OP_READ_POS = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;     // clear one id_live entry
      logic issue;     // latch request, launch first reads
      logic eval;      // first read data back: decide, first writes
      logic fetch;     // get: element read back
      logic move;      // delete: final position_to_id write, count down
      logic load_rsp;  // move result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic need_fetch;
      logic need_move;
      logic rsp_busy;
   } stat_type;

endpackage

[hw/rtl/sipt_ctrl.sv]
// ----------------------------------------------------------------------------
// sipt_ctrl
// Sequencer for the packed table: clearing pass, then one request at a time.
// ----------------------------------------------------------------------------
module sipt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sipt_pkg::stat_type stat,
   output sipt_pkg::cmd_type  cmd
);
   import sipt_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_FETCH,
      S_MOVE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.issue = 1'b1;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.need_fetch) begin
               state_in = S_FETCH;
            end else if (stat.need_move) begin
               state_in = S_MOVE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_DONE;
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

[hw/rtl/sipt_dpath.sv]
// ----------------------------------------------------------------------------
// sipt_dpath
// Table memories, count, request and result registers, output register.
// ----------------------------------------------------------------------------
`include "stable_id_packed_table_top_defines.svh"

module sipt_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  sipt_pkg::cmd_type              cmd,
   output sipt_pkg::stat_type             stat,
   input  logic [sipt_pkg::OP_W-1:0]      req_operation,
   input  logic [sipt_pkg::ID_W-1:0]      req_item_id,
   input  logic [sipt_pkg::ADDR_W-1:0]    req_position,
   input  logic [sipt_pkg::DATA_W-1:0]    req_element,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [sipt_pkg::STAT_W-1:0]    rsp_status,
   output logic [sipt_pkg::ID_W-1:0]      rsp_result_id,
   output logic [sipt_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [sipt_pkg::CNT_W-1:0]     rsp_live_count
);
   import sipt_pkg::*;

   // memories
   logic [DATA_W-1:0] store_mem [DEPTH];
   logic [ADDR_W-1:0] i2p_mem   [DEPTH];
   logic [ID_W-1:0]   p2i_mem   [DEPTH];
   logic              live_mem  [DEPTH];

   // registered read data
   logic [DATA_W-1:0] store_q;
   logic [ADDR_W-1:0] i2p_q;
   logic [ID_W-1:0]   p2i_q;
   logic              live_q;
   logic [ADDR_W-1:0] p2i_ra_ff;

   // control registers
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  hw_ff, hw_in;        // highest count reached
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // request and result payload
   op_type            op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [ADDR_W-1:0] pos_ff;
   logic [DATA_W-1:0] elem_ff;
   status_type        res_stat_ff, res_stat_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic [DATA_W-1:0] res_data_ff, res_data_in;
   status_type        out_stat_ff;
   logic [ID_W-1:0]   out_id_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic [CNT_W-1:0]  out_cnt_ff;

   // write ports
   logic              store_we, i2p_we, p2i_we, live_we;
   logic [ADDR_W-1:0] store_wa, i2p_wa, p2i_wa, live_wa;
   logic [DATA_W-1:0] store_wd;
   logic [ADDR_W-1:0] i2p_wd;
   logic [ID_W-1:0]   p2i_wd;
   logic              live_wd;

   // read ports
   logic              store_re;
   logic [ADDR_W-1:0] store_ra, p2i_ra;

   op_type            req_op;
   logic [CNT_W-1:0]  last_cnt;
   logic [ADDR_W-1:0] last_idx, cnt_idx;
   logic [ID_W-1:0]   p2i_val;
   logic              full, pos_ok, need_fetch, need_move, push_ok;

   assign req_op   = op_type'(req_operation);
   assign last_cnt = count_ff - CNT_W'(1);
   assign last_idx = last_cnt[ADDR_W-1:0];
   assign cnt_idx  = count_ff[ADDR_W-1:0];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign pos_ok   = ({1'b0, pos_ff} < count_ff);
   assign push_ok  = cmd.eval && (op_ff == OP_PUSH) && !full;

   // entries at or past the high-water mark were never written: entry i is i
   assign p2i_val  = ({1'b0, p2i_ra_ff} < hw_ff) ? p2i_q : ID_W'(p2i_ra_ff);

   assign need_fetch = (op_ff == OP_GET) && live_q;
   assign need_move  = (op_ff == OP_DELETE) && live_q && (count_ff != '0);

   assign stat.clear_last = (clr_ff == {ADDR_W{1'b1}});
   assign stat.need_fetch = need_fetch;
   assign stat.need_move  = need_move;
   assign stat.rsp_busy   = rsp_valid_ff && rsp_stall;

   // read address selection
   assign p2i_ra   = (req_op == OP_PUSH) ? cnt_idx : last_idx;
   assign store_re = cmd.issue || (cmd.eval && need_fetch);
   assign store_ra = cmd.issue ? ((req_op == OP_READ_POS) ? req_position : last_idx)
                               : i2p_q;

   // write port selection
   always_comb begin
      store_we = 1'b0; store_wa = '0; store_wd = '0;
      i2p_we   = 1'b0; i2p_wa   = '0; i2p_wd   = '0;
      p2i_we   = 1'b0; p2i_wa   = '0; p2i_wd   = '0;
      live_we  = 1'b0; live_wa  = '0; live_wd  = 1'b0;
      if (cmd.clear) begin
         live_we = 1'b1;
         live_wa = clr_ff;
      end
      if (cmd.eval) begin
         case (op_ff)
            OP_PUSH: begin
               if (!full) begin
                  store_we = 1'b1; store_wa = cnt_idx;          store_wd = elem_ff;
                  i2p_we   = 1'b1; i2p_wa   = ADDR_W'(p2i_val); i2p_wd   = cnt_idx;
                  live_we  = 1'b1; live_wa  = ADDR_W'(p2i_val); live_wd  = 1'b1;
                  // pin the taken id so the entry reads back once under the mark
                  p2i_we   = 1'b1; p2i_wa   = cnt_idx;          p2i_wd   = p2i_val;
               end
            end
            OP_DELETE: begin
               if (need_move) begin
                  // last element into the hole, moved id points at the hole
                  store_we = 1'b1; store_wa = i2p_q;            store_wd = store_q;
                  i2p_we   = 1'b1; i2p_wa   = ADDR_W'(p2i_val); i2p_wd   = i2p_q;
                  p2i_we   = 1'b1; p2i_wa   = i2p_q;            p2i_wd   = p2i_val;
                  live_we  = 1'b1; live_wa  = ADDR_W'(id_ff);   live_wd  = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.move) begin
         // freed id parks just past the packed region
         p2i_we = 1'b1; p2i_wa = last_idx; p2i_wd = id_ff;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wa] <= store_wd;
      end
      if (store_re) begin
         store_q <= store_mem[store_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (i2p_we) begin
         i2p_mem[i2p_wa] <= i2p_wd;
      end
      if (cmd.issue) begin
         i2p_q <= i2p_mem[ADDR_W'(req_item_id)];
      end
   end

   always_ff @(posedge clock) begin
      if (p2i_we) begin
         p2i_mem[p2i_wa] <= p2i_wd;
      end
      if (cmd.issue) begin
         p2i_q     <= p2i_mem[p2i_ra];
         p2i_ra_ff <= p2i_ra;
      end
   end

   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem[live_wa] <= live_wd;
      end
      if (cmd.issue) begin
         live_q <= live_mem[ADDR_W'(req_item_id)];
      end
   end

   // next-state logic
   always_comb begin
      count_in     = count_ff;
      hw_in        = hw_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      res_stat_in  = res_stat_ff;
      res_id_in    = res_id_ff;
      res_data_in  = res_data_ff;

      if (cmd.clear) begin
         clr_in = clr_ff + ADDR_W'(1);
      end
      if (cmd.eval) begin
         res_stat_in = ST_INVALID;
         res_id_in   = '0;
         res_data_in = '0;
         case (op_ff)
            OP_PUSH: begin
               if (full) begin
                  res_stat_in = ST_FULL;
               end else begin
                  res_stat_in = ST_OK;
                  res_id_in   = p2i_val;
                  count_in    = count_ff + CNT_W'(1);
                  if (count_ff == hw_ff) begin
                     hw_in = hw_ff + CNT_W'(1);
                  end
               end
            end
            OP_GET: begin
               if (live_q) begin
                  res_stat_in = ST_OK;
               end
            end
            OP_DELETE: begin
               if (need_move) begin
                  res_stat_in = ST_OK;
               end
            end
            OP_READ_POS: begin
               if (pos_ok) begin
                  res_stat_in = ST_OK;
                  res_data_in = store_q;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.fetch) begin
         res_data_in = store_q;
      end
      if (cmd.move) begin
         count_in = last_cnt;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         hw_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         hw_ff        <= hw_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_stat_ff <= res_stat_in;
      res_id_ff   <= res_id_in;
      res_data_ff <= res_data_in;
      if (cmd.issue) begin
         op_ff   <= req_op;
         id_ff   <= req_item_id;
         pos_ff  <= req_position;
         elem_ff <= req_element;
      end
      if (cmd.load_rsp) begin
         out_stat_ff <= res_stat_ff;
         out_id_ff   <= res_id_ff;
         out_data_ff <= res_data_ff;
         out_cnt_ff  <= count_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = STAT_W'(out_stat_ff);
   assign rsp_result_id  = out_id_ff;
   assign rsp_read_data  = out_data_ff;
   assign rsp_live_count = out_cnt_ff;

   `SIPT_ASSERT_ALWAYS(a_count_cap, count_ff <= CNT_W'(DEPTH), "count beyond capacity")
   `SIPT_ASSERT_ALWAYS(a_hw_covers, hw_ff >= count_ff, "high-water mark below count")
   `SIPT_ASSERT_NEXT(a_move_dec, cmd.move, count_ff == $past(count_ff) - CNT_W'(1), "del count")
   `SIPT_ASSERT_NEXT(a_push_inc, push_ok, count_ff == $past(count_ff) + CNT_W'(1), "push count")

endmodule

[hw/rtl/stable_id_packed_table_top.sv]
// ----------------------------------------------------------------------------
// stable_id_packed_table_top
// Fixed-capacity packed table with stable IDs: push, get by id, delete by id,
// read by packed position. One result per request.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   req_    | in        | req_valid/req_stall  | operation, item_id, position,
//           |           |                      | element
//   rsp_    | out       | rsp_valid/rsp_stall  | status, result_id, read_data,
//           |           |                      | live_count
//
// Sequence: push, read-at-position and rejected requests pass the evaluate
//   and done states; get and a valid delete add a fetch or move state, set
//   by the chain of registered memory reads: get needs the id map before
//   the element read, delete needs two position_to_id writes.
// Reset: synchronous; afterwards a clearing pass zeroes all 1024 per-id live
//   bits, with req_stall high throughout.
// Stalls: the output register lets the next request be accepted while a
//   result waits; a request finishing into a full output register waits.
// ----------------------------------------------------------------------------
module stable_id_packed_table_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sipt_pkg::OP_W-1:0]      req_operation,
   input  logic [sipt_pkg::ID_W-1:0]      req_item_id,
   input  logic [sipt_pkg::ADDR_W-1:0]    req_position,
   input  logic [sipt_pkg::DATA_W-1:0]    req_element,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sipt_pkg::STAT_W-1:0]    rsp_status,
   output logic [sipt_pkg::ID_W-1:0]      rsp_result_id,
   output logic [sipt_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [sipt_pkg::CNT_W-1:0]     rsp_live_count
);
   import sipt_pkg::*;

   cmd_type  cmd;   // sequencer commands
   stat_type stat;  // datapath status back to the sequencer

   // sequencer: clearing pass, then one request at a time
   sipt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // memories, count, high-water mark and result/output registers
   sipt_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_operation  (req_operation),
      .req_item_id    (req_item_id),
      .req_position   (req_position),
      .req_element    (req_element),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_result_id  (rsp_result_id),
      .rsp_read_data  (rsp_read_data),
      .rsp_live_count (rsp_live_count)
   );

endmodule
